[src/nir_pkg.sv]
`timescale 1ns / 1ps

package nir_pkg;

	// Frame geometry of the decoder.
	localparam int CODE_BITS = 32;
	localparam int CODE_W = 32;
	localparam int CODE_IDX_W = $clog2(CODE_W);
	localparam int COUNT_W = 6;
	localparam int STATUS_W = 3;
	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 48;

	// Pulse timing windows in microseconds. All bounds are exclusive.
	localparam logic [TIME_W-1:0] START_BURST_LO = 32'd8500;
	localparam logic [TIME_W-1:0] START_BURST_HI = 32'd9500;
	localparam logic [TIME_W-1:0] FRAME_GAP_LO = 32'd4800;
	localparam logic [TIME_W-1:0] FRAME_GAP_HI = 32'd5300;
	localparam logic [TIME_W-1:0] REPEAT_GAP_LO = 32'd2700;
	localparam logic [TIME_W-1:0] REPEAT_GAP_HI = 32'd3300;
	localparam logic [TIME_W-1:0] ZERO_LO = 32'd900;
	localparam logic [TIME_W-1:0] ZERO_HI = 32'd1300;
	localparam logic [TIME_W-1:0] ONE_LO = 32'd2000;
	localparam logic [TIME_W-1:0] ONE_HI = 32'd2500;

	localparam logic [CODE_W-1:0] CHECK_MASK = 32'h00ff_0000;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_W-1:0] BURST_MIN_RST = 16'd500;
	localparam logic [CFG_W-1:0] BURST_MAX_RST = 16'd700;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BURST_MIN = 1'b0,
		REG_BURST_MAX = 1'b1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IDLE     = 3'd0,
		ST_PREAMBLE = 3'd1,
		ST_ACTIVE   = 3'd2,
		ST_REPEAT   = 3'd3,
		ST_COMPLETE = 3'd4,
		ST_ERROR    = 3'd5
	} dec_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] burst_min;
		logic [CFG_W-1:0] burst_max;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  bit_count;
		logic [CODE_W-1:0]   code;
		logic [STATUS_W-1:0] status;
	} dec_view_t;

	// Open interval test.
	function automatic logic in_window(input logic [TIME_W-1:0] v,
			input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
		in_window = (v > lo) && (v < hi);
	endfunction

	// The command byte must be the bitwise inverse of the byte above it.
	function automatic logic bytes_inverse(input logic [CODE_W-1:0] c);
		bytes_inverse = ((c ^ (c >> 8)) & CHECK_MASK) == CHECK_MASK;
	endfunction

endpackage

[src/nec_ir_pulse_decoder_top.sv]
`timescale 1ns / 1ps

// NEC infrared pulse decoder.
//
// Every input beat on the s_ channel is one edge of the infrared receiver:
// s_tuser carries the level after the edge and s_tdata the 32-bit
// microsecond timestamp. Each beat, falling edges included, yields exactly
// one output beat on the m_ channel carrying the decoder status, the code
// assembled so far and the received bit count.
// The cfg channel writes the data burst window: index 0 is the minimum and
// index 1 the maximum burst length in microseconds. It is always ready and
// should only be written while no edge is in flight.
// An accepted edge lands in the input register and is decoded once the output
// register is free or being read; its result is then written to the output
// register, which drives m_tvalid. One edge is accepted every cycle while the
// receiver does not stall; the decoder state feeds back from one edge to the
// next through the state registers of the core.
// When the receiver stalls, the result waits in the output register and
// another edge waits in the input register; only then does s_tready drop.
// Reset clears the decoder to idle with all times, code and count at zero,
// empties both registers and restores the burst window to 500 and 700 us.
module nec_ir_pulse_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] time_us
	input  logic [nir_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] edge_level
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] status, [34:3] code, [40:35] bit_count, [47:41] zero
	output logic [nir_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nir_pkg::CFG_W-1:0]     cfg_data
);
	import nir_pkg::*;

	cfg_t              cfg;
	dec_view_t         view;

	logic              valid_s1;
	logic              level_s1;
	logic [TIME_W-1:0] time_s1;
	logic              advance;
	logic              out_valid_q;
	dec_view_t         out_q;

	// The held edge moves on when the output register is free or being read.
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	nir_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nir_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.edge_level (level_s1),
		.time_us    (time_s1),
		.cfg        (cfg),
		.view       (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tuser;
			time_s1 <= s_tdata[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= view;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(M_TDATA_W-$bits(dec_view_t)){1'b0}}, out_q};

	a_hold_edge: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(time_s1) && $stable(level_s1))
		else $error("a stalled edge was dropped from the input register");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("a decoded edge gave no output beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !advance)
		else $error("output register overwritten while stalled");

endmodule

[src/nir_cfg_regs.sv]
`timescale 1ns / 1ps

module nir_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nir_pkg::CFG_W-1:0]     cfg_data,
	output nir_pkg::cfg_t                 cfg
);
	import nir_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_min <= BURST_MIN_RST;
			cfg_q.burst_max <= BURST_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BURST_MIN: cfg_q.burst_min <= cfg_data;
				REG_BURST_MAX: cfg_q.burst_max <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[src/nir_core.sv]
`timescale 1ns / 1ps

module nir_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       edge_level,
	input  logic [nir_pkg::TIME_W-1:0] time_us,
	input  nir_pkg::cfg_t              cfg,
	output nir_pkg::dec_view_t         view
);
	import nir_pkg::*;

	logic [TIME_W-1:0]  fall_q, fall_d;
	logic [TIME_W-1:0]  rise_q, rise_d;
	logic [CODE_W-1:0]  code_q, code_d;
	logic [COUNT_W-1:0] bit_q, bit_d;
	dec_state_t         state_q, state_d;

	logic [TIME_W-1:0]  burst;
	logic [TIME_W-1:0]  period;
	logic               bad_burst;
	logic               is_zero;
	logic               is_one;
	logic [COUNT_W-1:0] bit_inc;

	assign burst = time_us - fall_q;
	assign period = time_us - rise_q;
	assign bad_burst = (burst < {{(TIME_W-CFG_W){1'b0}}, cfg.burst_min}) ||
		(burst > {{(TIME_W-CFG_W){1'b0}}, cfg.burst_max});
	assign is_zero = in_window(period, ZERO_LO, ZERO_HI);
	assign is_one = in_window(period, ONE_LO, ONE_HI);
	assign bit_inc = (bit_q == COUNT_MAX) ? bit_q : bit_q + 1'b1;

	always_comb begin
		fall_d = fall_q;
		rise_d = rise_q;
		code_d = code_q;
		bit_d = bit_q;
		state_d = state_q;
		if (step) begin
			if (!edge_level) begin
				fall_d = time_us;
			end else begin
				rise_d = time_us;
				if (in_window(burst, START_BURST_LO, START_BURST_HI)) begin
					bit_d = '0;
					state_d = ST_PREAMBLE;
				end else if (bad_burst) begin
					state_d = ST_ERROR;
				end else begin
					case (state_q)
						ST_PREAMBLE: begin
							if (in_window(period, FRAME_GAP_LO, FRAME_GAP_HI)) begin
								code_d = '0;
								bit_d = '0;
								state_d = ST_ACTIVE;
							end else if (in_window(period, REPEAT_GAP_LO,
									REPEAT_GAP_HI)) begin
								state_d = bytes_inverse(code_q) ? ST_REPEAT : ST_ERROR;
							end
						end
						ST_ACTIVE: begin
							if (is_zero || is_one) begin
								if (is_one && (bit_q < COUNT_W'(CODE_BITS)) &&
										(bit_q < COUNT_W'(CODE_W))) begin
									code_d = code_q |
										(CODE_W'(1) << bit_q[CODE_IDX_W-1:0]);
								end
								bit_d = bit_inc;
								if (bit_inc == COUNT_W'(CODE_BITS)) begin
									state_d = bytes_inverse(code_d) ? ST_COMPLETE : ST_ERROR;
								end
							end else begin
								state_d = ST_ERROR;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_q <= '0;
			rise_q <= '0;
			code_q <= '0;
			bit_q <= '0;
			state_q <= ST_IDLE;
		end else begin
			fall_q <= fall_d;
			rise_q <= rise_d;
			code_q <= code_d;
			bit_q <= bit_d;
			state_q <= state_d;
		end
	end

	// The result of a beat is the state right after it.
	assign view.status = state_d;
	assign view.code = code_d;
	assign view.bit_count = bit_d;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= COUNT_W'(CODE_BITS))
		else $error("bit count ran past the frame length");

	a_complete_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPLETE |-> bit_q == COUNT_W'(CODE_BITS))
		else $error("frame complete without a full bit count");

	a_active_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACTIVE |-> (code_q >> bit_q) == '0)
		else $error("code holds bits above the received count");

	a_fall_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		step && !edge_level |=> $stable(state_q) && $stable(code_q) && $stable(bit_q))
		else $error("falling edge changed the decoder state");

endmodule

[test/nec_ir_pulse_decoder_top_tb.sv]
`timescale 1ns / 1ps

module nec_ir_pulse_decoder_top_tb;

	import nir_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int REPORT_LIMIT = 10;

	// Tracks the decoder state from the accepted edges and keeps the views that the
	// decoder still owes, oldest first.
	class ir_frame_board;
		logic [CFG_W-1:0]    burst_min = BURST_MIN_RST;
		logic [CFG_W-1:0]    burst_max = BURST_MAX_RST;
		logic [TIME_W-1:0]   fall_us = '0;
		logic [TIME_W-1:0]   rise_us = '0;
		logic [CODE_W-1:0]   code_bits = '0;
		logic [COUNT_W-1:0]  bits_seen = '0;
		dec_state_t          dec_st = ST_IDLE;
		dec_view_t           awaited_views[$];
		int                  errors = 0;

		function automatic bit strictly_between(logic [TIME_W-1:0] v,
				logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
			return (v > lo) && (v < hi);
		endfunction

		// The command byte has to be the bitwise inverse of the byte above it.
		function automatic bit cmd_inverted(logic [CODE_W-1:0] c);
			return (c[23:16] ^ c[31:24]) == 8'hff;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			if (idx == REG_BURST_MIN)
				burst_min = v;
			else
				burst_max = v;
		endfunction

		function void note_edge(logic level, logic [TIME_W-1:0] t);
			logic [TIME_W-1:0] burst;
			logic [TIME_W-1:0] span;
			bit is_zero;
			bit is_one;
			if (!level) begin
				fall_us = t;
			end else begin
				burst = t - fall_us;
				span = t - rise_us;
				rise_us = t;
				if (strictly_between(burst, START_BURST_LO, START_BURST_HI)) begin
					// A start burst wins over everything else, in any state.
					bits_seen = '0;
					dec_st = ST_PREAMBLE;
				end else if (burst < {16'b0, burst_min} || burst > {16'b0, burst_max}) begin
					dec_st = ST_ERROR;
				end else if (dec_st == ST_PREAMBLE) begin
					if (strictly_between(span, FRAME_GAP_LO, FRAME_GAP_HI)) begin
						code_bits = '0;
						bits_seen = '0;
						dec_st = ST_ACTIVE;
					end else if (strictly_between(span, REPEAT_GAP_LO, REPEAT_GAP_HI)) begin
						dec_st = cmd_inverted(code_bits) ? ST_REPEAT : ST_ERROR;
					end
				end else if (dec_st == ST_ACTIVE) begin
					is_zero = strictly_between(span, ZERO_LO, ZERO_HI);
					is_one = strictly_between(span, ONE_LO, ONE_HI);
					if (is_zero || is_one) begin
						if (is_one && bits_seen < CODE_BITS)
							code_bits[bits_seen[4:0]] = 1'b1;
						if (bits_seen != COUNT_MAX)
							bits_seen = bits_seen + 1'b1;
					end else begin
						dec_st = ST_ERROR;
					end
					if (dec_st == ST_ACTIVE && bits_seen == CODE_BITS)
						dec_st = cmd_inverted(code_bits) ? ST_COMPLETE : ST_ERROR;
				end
			end
			awaited_views.push_back('{bit_count: bits_seen, code: code_bits, status: dec_st});
		endfunction

		function void check_view(logic [M_TDATA_W-1:0] beat);
			dec_view_t got;
			dec_view_t want;
			got = dec_view_t'(beat[$bits(dec_view_t)-1:0]);
			if (awaited_views.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result beat: status %0d code %h count %0d",
						got.status, got.code, got.bit_count);
				return;
			end
			want = awaited_views.pop_front();
			if (got.status != want.status || got.code != want.code ||
					got.bit_count != want.bit_count) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display({"result mismatch: expected status %0d code %h count %0d,",
						" got status %0d code %h count %0d"},
						want.status, want.code, want.bit_count,
						got.status, got.code, got.bit_count);
			end
		endfunction

		function int pending();
			return awaited_views.size();
		endfunction

		function bit clean();
			return errors == 0 && awaited_views.size() == 0;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	ir_frame_board board;
	logic [TIME_W-1:0] last_rise_us = '0;
	int edges_sent = 0;
	int quiet = 0;
	bit send_calm = 1'b0;

	nec_ir_pulse_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TIME_W-1:0] start_burst();
		return $urandom_range(8501, 9499);
	endfunction

	// A burst inside the programmed window; any burst when the window is empty.
	function automatic logic [TIME_W-1:0] data_burst();
		int unsigned lo;
		int unsigned hi;
		lo = {16'b0, board.burst_min};
		hi = {16'b0, board.burst_max};
		if (lo > hi)
			return $urandom_range(0, 65535);
		if (hi - lo > 800)
			hi = lo + 800;
		return $urandom_range(lo, hi);
	endfunction

	function automatic logic [TIME_W-1:0] bound_burst();
		logic [TIME_W-1:0] b;
		case ($urandom_range(0, 7))
			0: b = {16'b0, board.burst_min} - 1;
			1: b = {16'b0, board.burst_min};
			2: b = {16'b0, board.burst_max};
			3: b = {16'b0, board.burst_max} + 1;
			4: b = START_BURST_LO;
			5: b = START_BURST_LO + 1;
			6: b = START_BURST_HI - 1;
			default: b = START_BURST_HI;
		endcase
		return b;
	endfunction

	// A rise-to-rise time on or right beside one of the timing window edges.
	function automatic logic [TIME_W-1:0] near_bound();
		logic [TIME_W-1:0] b;
		case ($urandom_range(0, 7))
			0: b = FRAME_GAP_LO;
			1: b = FRAME_GAP_HI;
			2: b = REPEAT_GAP_LO;
			3: b = REPEAT_GAP_HI;
			4: b = ZERO_LO;
			5: b = ZERO_HI;
			6: b = ONE_LO;
			default: b = ONE_HI;
		endcase
		return b + $urandom_range(0, 2) - 1;
	endfunction

	task automatic pace_sender();
		int gap;
		if ($urandom_range(0, 199) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Presents one edge beat and holds it until the decoder takes it.
	task automatic send_edge(input logic level, input logic [TIME_W-1:0] t);
		s_tvalid <= 1'b1;
		s_tuser <= level;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		board.note_edge(level, t);
		if (level)
			last_rise_us = t;
		edges_sent++;
		pace_sender();
	endtask

	// One low pulse: the rise lands span after the previous rise, the fall burst before it.
	task automatic send_pulse(input logic [TIME_W-1:0] burst, input logic [TIME_W-1:0] span);
		logic [TIME_W-1:0] rise;
		rise = last_rise_us + span;
		send_edge(1'b0, rise - burst);
		send_edge(1'b1, rise);
	endtask

	// Leader, frame gap and 32 bits LSB first. At break_at the frame is spoiled by
	// a bad bit time, a bad burst or a fresh start burst.
	task automatic send_frame(input logic [CODE_W-1:0] code, input int break_at);
		int i;
		logic [TIME_W-1:0] span;
		send_pulse(start_burst(), $urandom_range(12000, 120000));
		send_pulse(data_burst(), $urandom_range(4801, 5299));
		for (i = 0; i < CODE_BITS; i++) begin
			span = code[i] ? $urandom_range(2001, 2499) : $urandom_range(901, 1299);
			if (i == break_at) begin
				case ($urandom_range(0, 2))
					0: send_pulse(data_burst(), $urandom_range(1300, 2000));
					1: send_pulse({16'b0, board.burst_max} + $urandom_range(1, 300), span);
					default: send_pulse(start_burst(), span);
				endcase
				return;
			end
			send_pulse(data_burst(), span);
		end
	endtask

	task automatic send_repeat();
		send_pulse(start_burst(), $urandom_range(20000, 110000));
		send_pulse(data_burst(), $urandom_range(2701, 3299));
	endtask

	// Puts the decoder in preamble or in a frame, then hits it with timings on the
	// window edges.
	task automatic send_bound_probe();
		send_pulse(start_burst(), $urandom_range(12000, 120000));
		if ($urandom_range(0, 1))
			send_pulse(data_burst(), $urandom_range(4801, 5299));
		repeat (2) send_pulse($urandom_range(0, 1) ? bound_burst() : data_burst(), near_bound());
	endtask

	// Holds the sender back until every result has come out and the pipeline is empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.write_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic run_directed();
		// Too short a burst straight out of idle.
		send_edge(1'b1, 32'h0000_0000);
		// A start burst measured across the timestamp wrap.
		send_edge(1'b0, 32'hffff_ffff);
		send_edge(1'b1, 32'h0000_2327);
		// A gap that is neither a frame start nor a repeat leaves preamble alone.
		send_pulse(600, 1000);
		// A repeat with no valid code kept ends in error.
		send_pulse(600, 3000);
		// A good data burst changes nothing once in error.
		send_pulse(600, 2000);
		// A burst right on the lower start bound is a bad burst, not a start.
		send_pulse(START_BURST_LO, 50000);
		send_pulse(START_BURST_HI - 1, 50000);
		// Window edges are inclusive for the data burst.
		send_pulse({16'b0, BURST_MIN_RST}, 5000);
		send_pulse({16'b0, BURST_MAX_RST}, ZERO_HI - 1);
		send_pulse(600, ONE_LO + 1);
		// A bit time between the zero and one windows is an error.
		send_pulse(600, 1500);
		send_pulse(START_BURST_HI, 50000);
		send_pulse({16'b0, BURST_MAX_RST} + 1, 50000);
	endtask

	// A mix weighted towards whole frames, with repeats, broken frames, window
	// edge probes and random edges for the rest.
	task automatic run_phase(input int quota);
		int stop_at;
		int r;
		logic [CODE_W-1:0] code;
		stop_at = edges_sent + quota;
		send_edge(1'b1, $urandom);
		while (edges_sent < stop_at) begin
			r = $urandom_range(0, 99);
			code = $urandom;
			code[31:24] = ~code[23:16];
			if (r < 45) begin
				send_frame(code, -1);
				if ($urandom_range(0, 1))
					send_repeat();
			end else if (r < 55) begin
				code[24] = ~code[24];
				send_frame(code, -1);
				send_repeat();
			end else if (r < 65) begin
				send_frame(code, $urandom_range(0, CODE_BITS - 1));
			end else if (r < 75) begin
				send_repeat();
			end else if (r < 85) begin
				send_bound_probe();
			end else begin
				repeat (4) send_edge(1'($urandom_range(0, 1)), $urandom);
			end
			if ($urandom_range(0, 5) == 0)
				settle();
		end
		settle();
	endtask

	// The receiver stalls at random, with calm stretches where it never does.
	initial begin : sink_pacing
		int stall;
		bit calm;
		stall = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 149) == 0)
				calm = !calm;
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 20)
					stall = draw_gap();
			end
		end
	end

	// Every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_view(m_tdata);
	end

	// Ends a run in which nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		board = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of the burst window first, then a sweep that includes
		// the full range, an empty window and a single-value window.
		run_directed();
		settle();
		run_phase(70);

		write_reg(REG_BURST_MIN, 16'd0);
		write_reg(REG_BURST_MAX, 16'hffff);
		run_phase(80);

		write_reg(REG_BURST_MIN, 16'hffff);
		write_reg(REG_BURST_MAX, 16'd0);
		run_phase(80);

		write_reg(REG_BURST_MIN, 16'd560);
		write_reg(REG_BURST_MAX, 16'd560);
		run_phase(80);

		write_reg(REG_BURST_MAX, 16'd1200);
		write_reg(REG_BURST_MIN, 16'd300);
		run_phase(80);

		write_reg(REG_BURST_MIN, BURST_MIN_RST);
		write_reg(REG_BURST_MAX, BURST_MAX_RST);
		run_phase(80);

		settle();
		if (board.clean())
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
src/nir_pkg.sv
src/nir_cfg_regs.sv
src/nir_core.sv
src/nec_ir_pulse_decoder_top.sv
test/nec_ir_pulse_decoder_top_tb.sv
